>>> design/thermal_runaway_safety_monitor_macros.svh
// Assertion macros shared by the monitor's checker.
`ifndef THERMAL_RUNAWAY_SAFETY_MONITOR_MACROS_SVH
`define THERMAL_RUNAWAY_SAFETY_MONITOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TRSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TRSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/trsm_pkg.sv
// Shared types and constants of the thermal runaway safety monitor.
package trsm_pkg;

    localparam int CHANNELS = 8;
    localparam int TIME_W   = 32;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W    = (TIME_W > 32) ? TIME_W : 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_MAX_TEMP  = 3'd2;
    localparam logic [2:0] REG_MIN_TEMP  = 3'd3;
    localparam logic [2:0] REG_ERR_LIMIT = 3'd4;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_WARN  = 2'd1;
    localparam logic [1:0] STATUS_EMERG = 2'd2;

    typedef struct packed {
        logic [15:0]        threshold;
        logic [31:0]        timeout;
        logic signed [15:0] max_temp;
        logic signed [15:0] min_temp;
        logic [7:0]         err_limit;
    } t_cfg;

    // Classified snapshot, as held in the queue
    typedef struct packed {
        logic              clear;
        logic              in_range;
        logic [2:0]        channel;
        logic              over;
        logic              under;
        logic              sens_err;
        logic              valid;
        logic              autom;
        logic              drive;
        logic              dev_over;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [2:0] channel_echo;
        logic [7:0] channel_alarms;
        logic       sensor_alarm;
        logic       emergency_alarm;
        logic       shutdown_latch;
        logic       force_manual;
        logic       over_temp_fault;
        logic       under_temp_fault;
        logic [1:0] status;
    } t_result;

endpackage

>>> design/trsm_front.sv
// Front end: classifies one snapshot against the configured limits.
module trsm_front import trsm_pkg::*; (
    input  t_cfg               i_cfg,
    input  logic               i_clear_request,
    input  logic [2:0]         i_channel,
    input  logic signed [15:0] i_temperature,
    input  logic               i_data_valid,
    input  logic [7:0]         i_error_count,
    input  logic signed [15:0] i_setpoint,
    input  logic               i_auto_mode,
    input  logic               i_drive_active,
    input  logic [31:0]        i_time_ms,
    output t_item              o_item
);

    logic signed [16:0] dev;
    logic [16:0]        mag;

    always_comb begin
        dev = {i_setpoint[15], i_setpoint} - {i_temperature[15], i_temperature};
        mag = dev[16] ? 17'(-dev) : 17'(dev);

        o_item.clear    = i_clear_request;
        o_item.in_range = (int'(i_channel) < CHANNELS);
        o_item.channel  = i_channel;
        o_item.over     = (i_temperature > i_cfg.max_temp);
        o_item.under    = (i_temperature < i_cfg.min_temp);
        o_item.sens_err = !i_data_valid && (i_error_count >= i_cfg.err_limit);
        o_item.valid    = i_data_valid;
        o_item.autom    = i_auto_mode;
        o_item.drive    = i_drive_active;
        o_item.dev_over = (mag > {1'b0, i_cfg.threshold});
        o_item.now      = TIME_W'(i_time_ms);
    end

endmodule

>>> design/trsm_fifo.sv
// Short queue between the front end and the back end.
module trsm_fifo import trsm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> design/trsm_back.sv
// Back end: alarm state, runaway timers and the result register.
module trsm_back import trsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_timeout,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output t_result     o_res
);

    logic [7:0]          r_alarm;
    logic                r_sensor;
    logic                r_emerg;
    logic                r_stop;
    logic [CHANNELS-1:0] r_armed;
    logic [TIME_W-1:0]   r_start [CHANNELS];
    logic                r_out_valid;
    t_result             r_res;

    logic [7:0]          n_alarm;
    logic                n_sensor;
    logic                n_emerg;
    logic                n_stop;
    logic [CHANNELS-1:0] n_armed;
    logic                arm_wr;
    t_result             n_res;
    logic [CH_IDX_W-1:0] idx;
    logic [7:0]          bit_sel;
    logic [TIME_W-1:0]   elapsed;
    logic                autom_eff;

    assign o_pop   = i_q_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_comb begin
        idx       = CH_IDX_W'(i_item.channel);
        bit_sel   = 8'd1 << i_item.channel;
        elapsed   = i_item.now - r_start[idx];
        autom_eff = i_item.autom && i_item.valid;

        n_alarm  = r_alarm;
        n_sensor = r_sensor;
        n_emerg  = r_emerg;
        n_stop   = r_stop;
        n_armed  = r_armed;
        arm_wr   = 1'b0;

        n_res = '0;
        n_res.channel_echo = i_item.channel;

        if (i_item.clear) begin
            n_alarm  = '0;
            n_sensor = 1'b0;
            n_emerg  = 1'b0;
            n_stop   = 1'b0;
            n_armed  = '0;
        end else if (i_item.in_range) begin
            if (i_item.sens_err) begin
                n_sensor = 1'b1;
            end
            if (i_item.over) begin
                n_emerg = 1'b1;
                n_stop  = 1'b1;
            end
            // Auto channel with bad data goes to manual
            if (i_item.autom && !i_item.valid) begin
                n_res.force_manual = 1'b1;
                n_sensor = 1'b1;
            end
            n_res.over_temp_fault  = i_item.over;
            n_res.under_temp_fault = i_item.under;

            if (!n_stop) begin
                if (!i_item.valid) begin
                    n_alarm = n_alarm | bit_sel;
                end else if (!autom_eff) begin
                    n_alarm      = n_alarm & ~bit_sel;
                    n_armed[idx] = 1'b0;
                end else if (i_item.dev_over && i_item.drive) begin
                    if (!r_armed[idx]) begin
                        n_armed[idx] = 1'b1;
                        arm_wr       = 1'b1;
                    end else if (CMP_W'(elapsed) > CMP_W'(i_timeout)) begin
                        n_alarm = n_alarm | bit_sel;
                        n_emerg = 1'b1;
                    end
                end else begin
                    n_alarm      = n_alarm & ~bit_sel;
                    n_armed[idx] = 1'b0;
                end
                if (n_emerg) begin
                    n_stop = 1'b1;
                end
            end
        end

        n_res.channel_alarms  = n_alarm;
        n_res.sensor_alarm    = n_sensor;
        n_res.emergency_alarm = n_emerg;
        n_res.shutdown_latch  = n_stop;
        if (i_item.clear) begin
            n_res.status = STATUS_OK;
        end else if (n_stop) begin
            n_res.status = STATUS_EMERG;
        end else if ((n_alarm != '0) || n_sensor || n_emerg) begin
            n_res.status = STATUS_WARN;
        end else begin
            n_res.status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && arm_wr) begin
            r_start[idx] <= i_item.now;
        end
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm     <= '0;
            r_sensor    <= 1'b0;
            r_emerg     <= 1'b0;
            r_stop      <= 1'b0;
            r_armed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_alarm  <= n_alarm;
                r_sensor <= n_sensor;
                r_emerg  <= n_emerg;
                r_stop   <= n_stop;
                r_armed  <= n_armed;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/thermal_runaway_safety_monitor.sv
// Top level of the thermal runaway safety monitor: config registers, front, queue, back.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+----------------------------------
//  snapshot  | in        | i_in_valid / o_in_stall   | i_clear_request .. i_time_ms
//  result    | out       | o_out_valid / i_out_stall | o_channel_echo .. o_status
//  config    | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata (5 registers)
//
//  Throughput is one transaction per cycle while neither the queue nor the
//  result channel stalls; the back end reads and updates its state in the
//  same cycle that it pops a snapshot, so consecutive snapshots of the same
//  channel need no bubble. An accepted snapshot is written into the queue,
//  and its result is loaded into the result register when the back end pops it.
//  o_in_stall rises only when the four-entry queue is full; a stalled result
//  holds in the result register while the queue keeps filling.
//  Reset (i_rst_n low, synchronous) loads the register defaults, empties the
//  queue, clears all alarms and the emergency latch, and disarms every runaway timer.
module thermal_runaway_safety_monitor import trsm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // snapshot channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_clear_request,
    input  logic [2:0]         i_channel,
    input  logic signed [15:0] i_temperature,
    input  logic               i_data_valid,
    input  logic [7:0]         i_error_count,
    input  logic signed [15:0] i_setpoint,
    input  logic               i_auto_mode,
    input  logic               i_drive_active,
    input  logic [31:0]        i_time_ms,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_channel_echo,
    output logic [7:0]         o_channel_alarms,
    output logic               o_sensor_alarm,
    output logic               o_emergency_alarm,
    output logic               o_shutdown_latch,
    output logic               o_force_manual,
    output logic               o_over_temp_fault,
    output logic               o_under_temp_fault,
    output logic [1:0]         o_status,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg    r_cfg;
    t_item   front_item;
    t_item   q_item;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_result res;
    logic    cfg_wr;

    // ---------------------------------------------------------------
    // Configuration registers: write on the access phase, read anytime
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= 16'd160;
            r_cfg.timeout   <= 32'd60000;
            r_cfg.max_temp  <= 16'sd4800;
            r_cfg.min_temp  <= -16'sd800;
            r_cfg.err_limit <= 8'd5;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_THRESHOLD: r_cfg.threshold <= pwdata[15:0];
                REG_TIMEOUT:   r_cfg.timeout   <= pwdata;
                REG_MAX_TEMP:  r_cfg.max_temp  <= pwdata[15:0];
                REG_MIN_TEMP:  r_cfg.min_temp  <= pwdata[15:0];
                REG_ERR_LIMIT: r_cfg.err_limit <= pwdata[7:0];
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_THRESHOLD: prdata = {16'd0, r_cfg.threshold};
            REG_TIMEOUT:   prdata = r_cfg.timeout;
            REG_MAX_TEMP:  prdata = {{16{r_cfg.max_temp[15]}}, r_cfg.max_temp};
            REG_MIN_TEMP:  prdata = {{16{r_cfg.min_temp[15]}}, r_cfg.min_temp};
            REG_ERR_LIMIT: prdata = {24'd0, r_cfg.err_limit};
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front end: limit compares, deviation magnitude, fault screening
    // ---------------------------------------------------------------
    trsm_front u_front (
        .i_cfg           (r_cfg),
        .i_clear_request (i_clear_request),
        .i_channel       (i_channel),
        .i_temperature   (i_temperature),
        .i_data_valid    (i_data_valid),
        .i_error_count   (i_error_count),
        .i_setpoint      (i_setpoint),
        .i_auto_mode     (i_auto_mode),
        .i_drive_active  (i_drive_active),
        .i_time_ms       (i_time_ms),
        .o_item          (front_item)
    );

    // Hold off the source only when the queue has no free entry
    assign o_in_stall = q_full;

    trsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // ---------------------------------------------------------------
    // Back end: alarm state, per-channel runaway timers, result register
    // ---------------------------------------------------------------
    trsm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_cfg.timeout),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .i_stall   (i_out_stall),
        .o_valid   (o_out_valid),
        .o_res     (res)
    );

    assign o_channel_echo     = res.channel_echo;
    assign o_channel_alarms   = res.channel_alarms;
    assign o_sensor_alarm     = res.sensor_alarm;
    assign o_emergency_alarm  = res.emergency_alarm;
    assign o_shutdown_latch   = res.shutdown_latch;
    assign o_force_manual     = res.force_manual;
    assign o_over_temp_fault  = res.over_temp_fault;
    assign o_under_temp_fault = res.under_temp_fault;
    assign o_status           = res.status;

endmodule

>>> design/trsm_checker.sv
// Port-level checker for the thermal runaway safety monitor, with its bind.
`include "thermal_runaway_safety_monitor_macros.svh"

module trsm_checker import trsm_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_emergency_alarm,
    input logic       o_shutdown_latch,
    input logic       o_over_temp_fault,
    input logic [1:0] o_status
);

    `TRSM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")
    `TRSM_ASSERT_NOW(a_stop_status, o_out_valid && o_shutdown_latch, o_status == STATUS_EMERG, "bad status")
    `TRSM_ASSERT_NOW(a_emerg_latch, o_out_valid && o_emergency_alarm, o_shutdown_latch, "no latch")
    `TRSM_ASSERT_NOW(a_over_stop, o_out_valid && o_over_temp_fault, o_shutdown_latch, "no over latch")

endmodule

bind thermal_runaway_safety_monitor trsm_checker u_trsm_checker (.*);
